// ===== design/skvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Word types, command codes and cell control shared by the table and its cells.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int CAPACITY_DEF     = 64;
    localparam int KEY_BITS         = 16;
    localparam int VALUE_BITS       = 32;
    localparam int ENTRY_TOTAL_BITS = 7;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_command;

    typedef struct packed {
        t_command                command;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   new_value;
    } t_cmd_word;

    typedef struct packed {
        logic                        found;
        logic                        unchanged;
        logic [VALUE_BITS-1:0]       read_value;
        logic                        table_full;
        logic [ENTRY_TOTAL_BITS-1:0] entry_total;
    } t_result_word;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOOK,
        OP_SCAN,
        OP_UPDATE,
        OP_INSERT,
        OP_REMOVE,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cell_ctrl;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_cell_data;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] value;
    } t_scan;

endpackage
`default_nettype wire

// ===== design/skvt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table cell
// Holds one entry, compares it with the command key and trades entries with
// its neighbors on insert and remove; passes the hit wave to the right.
// ----------------------------------------------------------------------------
module skvt_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  skvt_pkg::t_cell_ctrl i_ctrl,
    input  skvt_pkg::t_cell_data i_left_data,
    input  wire                 i_left_gt,
    input  skvt_pkg::t_scan      i_left_scan,
    input  skvt_pkg::t_cell_data i_right_data,
    output skvt_pkg::t_cell_data o_data,
    output logic                o_gt,
    output skvt_pkg::t_scan      o_scan
);

    skvt_pkg::t_cell_data r_data;
    logic                 r_eq;
    logic                 r_gt;
    skvt_pkg::t_scan      r_scan;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            skvt_pkg::OP_LOOK: begin
                r_eq   <= r_data.valid && (r_data.key == i_ctrl.key);
                r_gt   <= r_data.valid && (r_data.key > i_ctrl.key);
                r_scan <= '0;
            end
            skvt_pkg::OP_SCAN: begin
                r_scan.hit   <= i_left_scan.hit | r_eq;
                r_scan.value <= r_eq ? r_data.value : i_left_scan.value;
            end
            skvt_pkg::OP_UPDATE: begin
                if (r_eq) begin
                    r_data.value <= i_ctrl.value;
                end
            end
            skvt_pkg::OP_INSERT: begin
                if (i_left_gt) begin
                    r_data <= i_left_data;
                end else if (r_gt || (!r_data.valid && i_left_data.valid)) begin
                    r_data <= '{valid: 1'b1, key: i_ctrl.key, value: i_ctrl.value};
                end
            end
            skvt_pkg::OP_REMOVE: begin
                if (r_data.valid && (r_eq || r_gt)) begin
                    r_data <= i_right_data;
                end
            end
            skvt_pkg::OP_CLEAR: begin
                r_data.valid <= 1'b0;
            end
            default: begin
            end
        endcase
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end
    end

    assign o_data = r_data;
    assign o_gt   = r_gt;
    assign o_scan = r_scan;

endmodule
`default_nettype wire

// ===== design/sorted_key_value_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key/value table
// Up to CAPACITY key/value pairs in ascending key order, kept in a row of cells.
// ----------------------------------------------------------------------------
// One command word is taken when start is high and busy is low. The result
// word stands on o_result, marked by o_done for exactly one cycle, and must
// be taken then. Every command passes through the same states from the accept
// edge to the next possible accept: a compare in all cells (ST_LOOK), the hit
// wave crossing the cell row (ST_SCAN), the shift or update of the cells
// (ST_APPLY), and the result cycle, in which start is taken again. After
// reset the table is empty and ready at once.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
    parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  skvt_pkg::t_cmd_word    i_cmd,
    output logic                  o_done,
    output skvt_pkg::t_result_word o_result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SC_W  = $clog2(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_APPLY
    } t_state;

    t_state                 r_state;
    logic [SC_W-1:0]        r_scan_cnt;
    logic [CNT_W-1:0]       r_count;
    skvt_pkg::t_cmd_word    r_cmd;
    skvt_pkg::t_result_word r_result;
    logic                   r_done;
    logic                   r_busy;

    skvt_pkg::t_cell_ctrl   w_ctrl;
    skvt_pkg::t_cell_data   w_data [CAPACITY];
    logic                   w_gt   [CAPACITY];
    skvt_pkg::t_scan        w_scan [CAPACITY];

    skvt_pkg::t_cell_op     n_apply_op;
    logic [CNT_W-1:0]       n_count;
    skvt_pkg::t_result_word n_result;
    logic                   w_hit;
    logic                   w_full;

    assign w_hit  = w_scan[CAPACITY-1].hit;
    assign w_full = (r_count == CNT_W'(CAPACITY));

    always_comb begin
        n_apply_op          = skvt_pkg::OP_HOLD;
        n_count             = r_count;
        n_result            = '0;
        n_result.found      = w_hit;
        unique case (r_cmd.command)
            skvt_pkg::CMD_PUT: begin
                if (w_hit) begin
                    n_apply_op         = skvt_pkg::OP_UPDATE;
                    n_result.unchanged = (w_scan[CAPACITY-1].value == r_cmd.new_value);
                end else if (w_full) begin
                    n_result.table_full = 1'b1;
                end else begin
                    n_apply_op = skvt_pkg::OP_INSERT;
                    n_count    = r_count + 1'b1;
                end
            end
            skvt_pkg::CMD_FIND: begin
                if (w_hit) begin
                    n_result.read_value = w_scan[CAPACITY-1].value;
                end
            end
            skvt_pkg::CMD_REMOVE: begin
                if (w_hit) begin
                    n_apply_op = skvt_pkg::OP_REMOVE;
                    n_count    = r_count - 1'b1;
                end else begin
                    n_result.unchanged = 1'b1;
                end
            end
            skvt_pkg::CMD_CLEAR: begin
                n_apply_op     = skvt_pkg::OP_CLEAR;
                n_count        = '0;
                n_result.found = 1'b0;
            end
            default: begin
            end
        endcase
        n_result.entry_total = skvt_pkg::ENTRY_TOTAL_BITS'(n_count);
    end

    always_comb begin
        w_ctrl.key   = r_cmd.key;
        w_ctrl.value = r_cmd.new_value;
        unique case (r_state)
            ST_LOOK:  w_ctrl.op = skvt_pkg::OP_LOOK;
            ST_SCAN:  w_ctrl.op = skvt_pkg::OP_SCAN;
            ST_APPLY: w_ctrl.op = n_apply_op;
            default:  w_ctrl.op = skvt_pkg::OP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_cmd   <= i_cmd;
                    r_busy  <= 1'b1;
                    r_state <= ST_LOOK;
                end
            end
            ST_LOOK: begin
                r_scan_cnt <= SC_W'(CAPACITY - 1);
                r_state    <= ST_SCAN;
            end
            ST_SCAN: begin
                r_scan_cnt <= r_scan_cnt - 1'b1;
                if (r_scan_cnt == '0) begin
                    r_state <= ST_APPLY;
                end
            end
            ST_APPLY: begin
                r_count  <= n_count;
                r_result <= n_result;
                r_done   <= 1'b1;
                r_busy   <= 1'b0;
                r_state  <= ST_IDLE;
            end
            default: begin
                r_state <= ST_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_busy  <= 1'b0;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            skvt_pkg::t_cell_data w_left_data;
            logic                 w_left_gt;
            skvt_pkg::t_scan      w_left_scan;
            skvt_pkg::t_cell_data w_right_data;

            if (g == 0) begin : g_first
                assign w_left_data = '{valid: 1'b1, key: '0, value: '0};
                assign w_left_gt   = 1'b0;
                assign w_left_scan = '0;
            end else begin : g_mid
                assign w_left_data = w_data[g-1];
                assign w_left_gt   = w_gt[g-1];
                assign w_left_scan = w_scan[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_right_data = '0;
            end else begin : g_inner
                assign w_right_data = w_data[g+1];
            end

            skvt_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_left_data  (w_left_data),
                .i_left_gt    (w_left_gt),
                .i_left_scan  (w_left_scan),
                .i_right_data (w_right_data),
                .o_data       (w_data[g]),
                .o_gt         (w_gt[g]),
                .o_scan       (w_scan[g])
            );
        end
    endgenerate

    assign busy     = r_busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.table_full) |->
            (o_result.entry_total == skvt_pkg::ENTRY_TOTAL_BITS'(CAPACITY)))
        else $error("refused put with room left");

endmodule
`default_nettype wire
